@@ src/fqfe_pkg.sv @@
`timescale 1ns / 1ps
package fqfe_pkg;

  // Largest target name the block compares against
  localparam int unsigned NAME_MAX_DEF = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_NAME_LO  = 2'd0;
  localparam logic [1:0] CFG_NAME_HI  = 2'd1;
  localparam logic [1:0] CFG_NAME_LEN = 2'd2;

  // Scanner phases
  localparam logic [2:0] PH_NAME     = 3'd0;
  localparam logic [2:0] PH_VALUE    = 3'd1;
  localparam logic [2:0] PH_ESC1     = 3'd2;
  localparam logic [2:0] PH_ESC2     = 3'd3;
  localparam logic [2:0] PH_FINISHED = 3'd4;

  // Query status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Special characters
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Target name as seen by the scanner
  typedef struct packed {
    logic [127:0] name_word;  // byte 0 in bits 7:0
    logic [4:0]   tlen;       // already clamped to the maximum
  } fqfe_tgt_t;

  // One result of the scanner
  typedef struct packed {
    logic       valid;
    logic       has_byte;
    logic [7:0] decoded_byte;
    logic       done_res;
    logic [1:0] status;
  } fqfe_res_t;

  // Hex digit decode: bit 4 flags a legal digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

@@ src/fqfe_cfg.sv @@
`timescale 1ns / 1ps
module fqfe_cfg import fqfe_pkg::*; #(
  parameter int unsigned NAME_MAX = NAME_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output fqfe_tgt_t   tgt
);

  localparam logic [4:0] LEN_CAP = 5'(NAME_MAX);

  logic [63:0] name_lo_r;
  logic [63:0] name_hi_r;
  logic [4:0]  name_len_r;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_lo_r  <= '0;
      name_hi_r  <= '0;
      name_len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NAME_LO:  name_lo_r  <= cfg_data;
        CFG_NAME_HI:  name_hi_r  <= cfg_data;
        CFG_NAME_LEN: name_len_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Clamp length to the supported maximum
  assign tgt.name_word = {name_hi_r, name_lo_r};
  assign tgt.tlen      = (name_len_r > LEN_CAP) ? LEN_CAP : name_len_r;

endmodule

@@ src/fqfe_parse.sv @@
`timescale 1ns / 1ps
module fqfe_parse import fqfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [7:0] query_byte,
  input  logic       last_byte,
  input  fqfe_tgt_t  tgt,
  output fqfe_res_t  res
);

  logic [2:0] phase_r,    phase_nxt;
  logic [4:0] pos_r,      pos_nxt;
  logic       still_r,    still_nxt;
  logic [3:0] esc_hi_r,   esc_hi_nxt;
  logic       seen_r,     seen_nxt;
  logic       matched_r,  matched_nxt;

  logic [7:0] tbyte;
  logic [4:0] hx;
  logic       emit;
  logic [7:0] vbyte;
  logic       has;
  logic       done;
  logic [1:0] st;

  assign tbyte = tgt.name_word[{pos_r[3:0], 3'b000} +: 8];
  assign hx    = hex_digit(query_byte);

  // Next state and result for the byte in the input register
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    still_nxt   = still_r;
    esc_hi_nxt  = esc_hi_r;
    seen_nxt    = seen_r;
    matched_nxt = matched_r;
    emit        = 1'b0;
    vbyte       = 8'd0;
    has         = 1'b0;
    done        = 1'b0;
    st          = ST_OK;

    unique case (phase_r)
      PH_NAME: begin
        if (query_byte == CH_EQ) begin
          matched_nxt = still_r && (pos_r == tgt.tlen);
          seen_nxt    = 1'b0;
          phase_nxt   = PH_VALUE;
          if (last_byte) begin
            done = 1'b1;
            st   = matched_nxt ? ST_EMPTY : ST_NOTFOUND;
          end
        end else if (query_byte == CH_AMP) begin
          done = 1'b1;
          st   = ST_INVALID;
        end else begin
          if (pos_r >= tgt.tlen || tbyte != query_byte) still_nxt = 1'b0;
          if (pos_r != 5'd31) pos_nxt = pos_r + 5'd1;
          if (last_byte) begin
            done = 1'b1;
            st   = ST_INVALID;
          end
        end
      end
      PH_VALUE: begin
        if (query_byte == CH_AMP) begin
          if (matched_r) begin
            done = 1'b1;
            st   = seen_r ? ST_OK : ST_EMPTY;
          end else begin
            // Unmatched pair: start over on the next name
            phase_nxt   = PH_NAME;
            pos_nxt     = 5'd0;
            still_nxt   = 1'b1;
            esc_hi_nxt  = 4'd0;
            seen_nxt    = 1'b0;
            matched_nxt = 1'b0;
            if (last_byte) begin
              done = 1'b1;
              st   = ST_NOTFOUND;
            end
          end
        end else if (query_byte == CH_PCT) begin
          phase_nxt = PH_ESC1;
          if (last_byte) begin
            done = 1'b1;
            st   = ST_INVALID;
          end
        end else begin
          emit  = 1'b1;
          vbyte = (query_byte == CH_PLUS) ? CH_SPACE : query_byte;
        end
      end
      PH_ESC1: begin
        if (!hx[4]) begin
          done = 1'b1;
          st   = ST_INVALID;
        end else begin
          esc_hi_nxt = hx[3:0];
          phase_nxt  = PH_ESC2;
          if (last_byte) begin
            done = 1'b1;
            st   = ST_INVALID;
          end
        end
      end
      PH_ESC2: begin
        if (!hx[4]) begin
          done = 1'b1;
          st   = ST_INVALID;
        end else begin
          emit      = 1'b1;
          vbyte     = {esc_hi_r, hx[3:0]};
          phase_nxt = PH_VALUE;
        end
      end
      default: ;
    endcase

    // Deliver decoded value bytes of the matched pair
    if (emit) begin
      if (matched_r) begin
        has      = 1'b1;
        seen_nxt = 1'b1;
      end
      if (last_byte) begin
        done = 1'b1;
        st   = matched_r ? ST_OK : ST_NOTFOUND;
      end
    end

    // Clear at query end, park after an early status
    if (last_byte) begin
      phase_nxt   = PH_NAME;
      pos_nxt     = 5'd0;
      still_nxt   = 1'b1;
      esc_hi_nxt  = 4'd0;
      seen_nxt    = 1'b0;
      matched_nxt = 1'b0;
    end else if (done) begin
      phase_nxt = PH_FINISHED;
    end
  end

  assign res.valid        = has || done;
  assign res.has_byte     = has;
  assign res.decoded_byte = has ? vbyte : 8'd0;
  assign res.done_res     = done;
  assign res.status       = done ? st : ST_OK;

  // Advance scanner state once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_NAME;
      pos_r     <= '0;
      still_r   <= 1'b1;
      esc_hi_r  <= '0;
      seen_r    <= 1'b0;
      matched_r <= 1'b0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      still_r   <= still_nxt;
      esc_hi_r  <= esc_hi_nxt;
      seen_r    <= seen_nxt;
      matched_r <= matched_nxt;
    end
  end

endmodule

@@ src/form_query_field_extractor_top.sv @@
`timescale 1ns / 1ps
// Form query field extractor.
// Input channel (in_valid/in_ready): one raw byte of a name=value&... query
// per item, in_last_byte set on the final byte. Result channel
// (out_valid/out_ready): at most one item per input byte, carrying a
// decoded value byte of the first pair whose name equals the programmed
// name, and/or the final status of the query (ok, empty value, invalid
// format, name not found). Bytes that produce nothing yield no result item.
// Configuration: write cfg_data into register cfg_index with cfg_we while
// the block is idle (0: name bytes 0-7, 1: name bytes 8-15, 2: length).
// Timing: a byte accepted into the input register is scanned from there, and
// its result is loaded into the output register when the byte is consumed.
// Throughput is one byte per cycle unless a new result meets a held one that
// the receiver stalls; the scanner state loops through one small update.
// Reset (synchronous, rst_n low) empties both registers, returns the
// scanner to the start of a name and clears the programmed name.
// When the receiver stalls with a result held, the next byte waits in the
// input register and in_ready drops only if that byte also has a result.
module form_query_field_extractor_top import fqfe_pkg::*; #(
  parameter int unsigned NAME_MAX = NAME_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_query_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_has_byte,
  output logic [7:0]  out_decoded_byte,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  fqfe_res_t  out_r;
  fqfe_tgt_t  tgt;
  fqfe_res_t  res;
  logic       advance;

  fqfe_cfg #(.NAME_MAX(NAME_MAX)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tgt       (tgt)
  );

  fqfe_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .query_byte (s1_byte_r),
    .last_byte  (s1_last_r),
    .tgt        (tgt),
    .res        (res)
  );

  // Consume the held byte unless its result has nowhere to go
  assign advance  = s1_valid_r && (!res.valid || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_query_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Result register: load on a new result, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_has_byte     = out_r.has_byte;
  assign out_decoded_byte = out_r.decoded_byte;
  assign out_done_res     = out_r.done_res;
  assign out_status       = out_r.status;

  // A held result always carries a byte or a status
  a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.has_byte || out_r.done_res))
    else $error("result item with neither byte nor status");

  // Decoded byte and status are zero when not flagged
  a_out_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.has_byte || out_r.decoded_byte == 8'd0) &&
                     (out_r.done_res || out_r.status == ST_OK)))
    else $error("unflagged result field is not zero");

  // A consumed byte with a result shows up on the output next cycle
  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.valid) |=> out_valid_r)
    else $error("result lost between scanner and output register");

  // A stalled byte stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r)))
    else $error("stalled input byte lost");

  // Never stall the scanner while the output slot is free
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |-> advance)
    else $error("scanner stalled with empty output register");

endmodule
